/* design/toef_pkg.sv */
// Package for the terminal output escape filter.
// Holds sizes, byte codes, phase codes, shared types and ring helpers.
// Has no dependencies; every design file but toef_ram imports it.
`default_nettype none

package toef_pkg;

    // Sizes of the scrollback ring and the chunk-end trim threshold.
    localparam int RING_DEPTH = 8192;
    localparam int CAP_BYTES  = 4096;

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int LEN_W  = $clog2(RING_DEPTH + 1);
    localparam int OFS_W  = 13;
    localparam int BYTE_W = 8;
    localparam int SUM_W  = ((LEN_W > OFS_W) ? LEN_W : OFS_W) + 1;

    localparam logic [LEN_W-1:0] DEPTH_L     = LEN_W'(RING_DEPTH);
    localparam logic [LEN_W-1:0] DEPTH_M1_L  = LEN_W'(RING_DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_S     = SUM_W'(RING_DEPTH);
    // A cap at or above the ring depth can never be exceeded, so it clamps to the depth.
    localparam int               CAP_EFF     = (CAP_BYTES < RING_DEPTH) ? CAP_BYTES : RING_DEPTH;
    localparam logic [LEN_W-1:0] CAP_L       = LEN_W'(CAP_EFF);
    localparam logic [LEN_W-1:0] KEEP_L      = LEN_W'(CAP_EFF * 3 / 4);

    // Request codes.
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Byte codes seen by the escape parser.
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_BSLASH    = 8'h5C;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CSI_FINAL_LO = 8'h40;
    localparam logic [7:0] CSI_FINAL_HI = 8'h7E;

    // Escape phase codes as shown on the output.
    localparam logic [1:0] PHASE_TEXT = 2'd0;
    localparam logic [1:0] PHASE_ESC  = 2'd1;
    localparam logic [1:0] PHASE_CSI  = 2'd2;
    localparam logic [1:0] PHASE_OSC  = 2'd3;

    typedef enum logic [3:0] {
        ESC_TEXT = 4'b0001,
        ESC_SEEN = 4'b0010,
        ESC_CSI  = 4'b0100,
        ESC_OSC  = 4'b1000
    } t_esc_state;

    typedef struct packed {
        logic [LEN_W-1:0] kept_len;
        logic [LEN_W-1:0] line_len;
        logic             cr_pending;
        t_esc_state       esc;
    } t_status;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_cmd;

    // Folds a sum below twice the depth back into the ring.
    function automatic logic [ADDR_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
        return t[ADDR_W-1:0];
    endfunction

    function automatic logic [1:0] phase_code(input t_esc_state e);
        logic [1:0] p;
        case (e)
            ESC_SEEN: p = PHASE_ESC;
            ESC_CSI:  p = PHASE_CSI;
            ESC_OSC:  p = PHASE_OSC;
            default:  p = PHASE_TEXT;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

/* design/toef_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package dependency.
`default_nettype none

module toef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* design/toef_ctrl.sv */
// Control state of the filter: escape parser, line and length tracking, ring pointers.
// Produces the ring memory command for each word. Depends on toef_pkg.
`default_nettype none

module toef_ctrl import toef_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_append,
    input  wire logic              i_read,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_chunk_end,
    input  wire logic [OFS_W-1:0]  i_read_offset,
    output t_mem_cmd               o_mem,
    output t_status                o_stat_next
);

    t_esc_state        r_esc, n_esc;
    logic              r_cr, n_cr;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_line, n_line;

    always_comb begin
        logic              v_store;
        logic [LEN_W-1:0]  v_drop;
        logic [ADDR_W-1:0] v_waddr;
        n_esc   = r_esc;
        n_cr    = r_cr;
        n_head  = r_head;
        n_len   = r_len;
        n_line  = r_line;
        v_store = 1'b0;
        v_drop  = '0;
        v_waddr = '0;
        if (i_append) begin
            case (r_esc)
                ESC_SEEN: begin
                    if (i_data_byte == CH_LBRACKET) begin
                        n_esc = ESC_CSI;
                    end else if (i_data_byte == CH_RBRACKET) begin
                        n_esc = ESC_OSC;
                    end else begin
                        n_esc = ESC_TEXT;
                    end
                end
                ESC_CSI: begin
                    if (i_data_byte >= CSI_FINAL_LO && i_data_byte <= CSI_FINAL_HI) begin
                        n_esc = ESC_TEXT;
                    end
                end
                ESC_OSC: begin
                    if (i_data_byte == CH_BEL || i_data_byte == CH_BSLASH) begin
                        n_esc = ESC_TEXT;
                    end
                end
                ESC_TEXT: begin
                    if (i_data_byte == CH_ESC) begin
                        n_esc = ESC_SEEN;
                    end else if (i_data_byte == CH_CR) begin
                        n_cr = 1'b1;
                    end else if (i_data_byte == CH_LF) begin
                        n_cr    = 1'b0;
                        v_store = 1'b1;
                    end else if (i_data_byte == CH_BS) begin
                        n_cr = 1'b0;
                        if (r_line != '0) begin
                            n_line = r_line - 1'b1;
                            n_len  = r_len - 1'b1;
                        end
                    end else if (i_data_byte != CH_BEL) begin
                        // A pending carriage return erases the current line first.
                        if (r_cr) begin
                            n_len  = r_len - r_line;
                            n_line = '0;
                            n_cr   = 1'b0;
                        end
                        v_store = 1'b1;
                    end
                end
                default: n_esc = ESC_TEXT;
            endcase

            if (v_store) begin
                // A full ring gives up its oldest byte.
                if (n_len >= DEPTH_L) begin
                    n_head = ring_wrap(SUM_W'(n_head) + SUM_W'(1));
                    n_len  = DEPTH_M1_L;
                end
                v_waddr = ring_wrap(SUM_W'(n_head) + SUM_W'(n_len));
                n_len   = n_len + 1'b1;
                n_line  = (i_data_byte == CH_LF) ? '0 : (n_line + 1'b1);
                if (n_line > n_len) begin
                    n_line = n_len;
                end
            end

            if (i_chunk_end && (n_len > CAP_L)) begin
                v_drop = n_len - KEEP_L;
                n_head = ring_wrap(SUM_W'(n_head) + SUM_W'(v_drop));
                n_len  = KEEP_L;
                if (n_line > n_len) begin
                    n_line = n_len;
                end
            end
        end

        o_mem.we    = v_store;
        o_mem.waddr = v_waddr;
        o_mem.wdata = i_data_byte;
        o_mem.re    = i_read && (SUM_W'(i_read_offset) < SUM_W'(r_len));
        o_mem.raddr = ring_wrap(SUM_W'(r_head) + SUM_W'(i_read_offset));

        o_stat_next.kept_len   = n_len;
        o_stat_next.line_len   = n_line;
        o_stat_next.cr_pending = n_cr;
        o_stat_next.esc        = n_esc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= ESC_TEXT;
            r_cr   <= 1'b0;
            r_head <= '0;
            r_len  <= '0;
            r_line <= '0;
        end else begin
            r_esc  <= n_esc;
            r_cr   <= n_cr;
            r_head <= n_head;
            r_len  <= n_len;
            r_line <= n_line;
        end
    end

    a_line_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line <= r_len)
        else $error("line length exceeds kept length");

    a_len_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= DEPTH_L)
        else $error("kept length exceeds ring depth");

    a_read_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_read && !i_append) |=> ($stable(r_len) && $stable(r_head) && $stable(r_line)))
        else $error("read request changed the ring state");

endmodule

`default_nettype wire

/* design/terminal_output_escape_filter_top.sv */
// Top level of the terminal output escape filter with ring scrollback.
// Instantiates toef_ctrl and toef_ram; depends on toef_pkg.
`default_nettype none

// The block takes one word per clock cycle while not stalled, appends and
// reads alike, and returns each result in the next cycle. Appends run through
// an escape parser that drops ANSI CSI and OSC sequences and BEL; kept bytes go
// into an 8192-byte ring held in one synchronous dual-port RAM, with one write
// and one registered read per cycle, which sets that rate. A read returns the
// byte at the given offset from the oldest kept byte, or zero with read_valid
// low when the offset is at or past the kept length. The RAM gets no clearing
// pass after reset: only kept offsets are ever read, and each was written first.
// The input accepts a new word while the output register drains, so the input
// stalls only when a result is waiting and the output side stalls too.
module terminal_output_escape_filter_top import toef_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_req_type,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_chunk_end,
    input  wire logic [OFS_W-1:0]  i_read_offset,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [BYTE_W-1:0]      o_read_data,
    output logic                   o_read_valid,
    output logic [LEN_W-1:0]       o_kept_length,
    output logic [LEN_W-1:0]       o_current_line_length,
    output logic                   o_overwrite_pending,
    output logic [1:0]             o_escape_phase
);

    logic        w_accept;
    t_mem_cmd    w_mem;
    t_status     w_stat_next;
    logic [BYTE_W-1:0] w_rdata;

    logic        r_out_valid;
    logic        r_read_hit;
    t_status     r_stat;

    // Stall only when a result is waiting and cannot leave this cycle.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    toef_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_append      (w_accept && (i_req_type == REQ_APPEND)),
        .i_read        (w_accept && (i_req_type == REQ_READ)),
        .i_data_byte   (i_data_byte),
        .i_chunk_end   (i_chunk_end),
        .i_read_offset (i_read_offset),
        .o_mem         (w_mem),
        .o_stat_next   (w_stat_next)
    );

    // The read data register only loads on a kept-offset read, so it holds
    // steady while a read result is stalled at the output.
    toef_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_hit <= w_mem.re;
            r_stat     <= w_stat_next;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_read_valid          = r_read_hit;
    assign o_read_data           = r_read_hit ? w_rdata : '0;
    assign o_kept_length         = r_stat.kept_len;
    assign o_current_line_length = r_stat.line_len;
    assign o_overwrite_pending   = r_stat.cr_pending;
    assign o_escape_phase        = phase_code(r_stat.esc);

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted word produced no result");

    a_stalled_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_read_hit) |=> $stable(w_rdata))
        else $error("read data changed while stalled");

    a_hit_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_read_hit) |-> (r_stat.kept_len != '0))
        else $error("read hit reported with empty scrollback");

endmodule

`default_nettype wire

/* sim/toef_scrollback_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the terminal output escape filter: follows both word channels,
// keeps its own copy of the parser state and the scrollback ring, and compares.
// Depends on toef_pkg for the ring sizes, byte codes and phase codes.

module toef_scrollback_checker import toef_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_req_type,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_chunk_end,
    input  logic [OFS_W-1:0]  i_read_offset,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [BYTE_W-1:0] i_read_data,
    input  logic              i_read_valid,
    input  logic [LEN_W-1:0]  i_kept_length,
    input  logic [LEN_W-1:0]  i_current_line_length,
    input  logic              i_overwrite_pending,
    input  logic [1:0]        i_escape_phase,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic [LEN_W-1:0]  kept;
        logic [LEN_W-1:0]  line;
        logic              cr;
        logic [1:0]        phase;
    } t_filter_result;

    // Shadow copy of the scrollback and the parser.
    logic [BYTE_W-1:0] ring_copy [RING_DEPTH];
    int                oldest_idx;
    int                kept_bytes;
    int                line_bytes;
    logic              cr_mark;
    logic [1:0]        phase;

    t_filter_result    results_due [$];
    int                fails;

    function automatic void clear_shadow();
        for (int i = 0; i < RING_DEPTH; i++) begin
            ring_copy[i] = '0;
        end
        oldest_idx = 0;
        kept_bytes = 0;
        line_bytes = 0;
        cr_mark    = 1'b0;
        phase      = PHASE_TEXT;
    endfunction

    // A full ring gives up its oldest byte to make room.
    function automatic void keep_byte(input logic [BYTE_W-1:0] b);
        if (kept_bytes >= RING_DEPTH) begin
            oldest_idx = (oldest_idx + 1) % RING_DEPTH;
            kept_bytes = RING_DEPTH - 1;
        end
        ring_copy[(oldest_idx + kept_bytes) % RING_DEPTH] = b;
        kept_bytes++;
        if (b == CH_LF) begin
            line_bytes = 0;
        end else begin
            line_bytes++;
        end
        if (line_bytes > kept_bytes) begin
            line_bytes = kept_bytes;
        end
    endfunction

    function automatic void filter_console_byte(input logic [BYTE_W-1:0] c);
        case (phase)
            PHASE_ESC: begin
                if (c == CH_LBRACKET) begin
                    phase = PHASE_CSI;
                end else if (c == CH_RBRACKET) begin
                    phase = PHASE_OSC;
                end else begin
                    phase = PHASE_TEXT;
                end
            end
            PHASE_CSI: begin
                if (c >= CSI_FINAL_LO && c <= CSI_FINAL_HI) begin
                    phase = PHASE_TEXT;
                end
            end
            PHASE_OSC: begin
                if (c == CH_BEL || c == CH_BSLASH) begin
                    phase = PHASE_TEXT;
                end
            end
            default: begin
                if (c == CH_ESC) begin
                    phase = PHASE_ESC;
                end else if (c == CH_CR) begin
                    cr_mark = 1'b1;
                end else if (c == CH_LF) begin
                    cr_mark = 1'b0;
                    keep_byte(CH_LF);
                end else if (c == CH_BS) begin
                    cr_mark = 1'b0;
                    if (line_bytes > 0) begin
                        line_bytes--;
                        kept_bytes--;
                    end
                end else if (c != CH_BEL) begin
                    // A pending carriage return erases the line before the new byte.
                    if (cr_mark) begin
                        kept_bytes -= line_bytes;
                        line_bytes = 0;
                        cr_mark    = 1'b0;
                    end
                    keep_byte(c);
                end
            end
        endcase
    endfunction

    function automatic void trim_to_cap();
        int keep_len;
        keep_len = CAP_BYTES * 3 / 4;
        if (kept_bytes > CAP_BYTES) begin
            oldest_idx = (oldest_idx + kept_bytes - keep_len) % RING_DEPTH;
            kept_bytes = keep_len;
            if (line_bytes > kept_bytes) begin
                line_bytes = kept_bytes;
            end
        end
    endfunction

    function automatic t_filter_result predict_result(input logic req,
                                                      input logic [BYTE_W-1:0] b,
                                                      input logic last,
                                                      input logic [OFS_W-1:0] ofs);
        t_filter_result r;
        r = '0;
        if (req == REQ_APPEND) begin
            filter_console_byte(b);
            if (last) begin
                trim_to_cap();
            end
        end else if (int'(ofs) < kept_bytes) begin
            r.valid = 1'b1;
            r.data  = ring_copy[(oldest_idx + int'(ofs)) % RING_DEPTH];
        end
        r.kept  = LEN_W'(kept_bytes);
        r.line  = LEN_W'(line_bytes);
        r.cr    = cr_mark;
        r.phase = phase;
        return r;
    endfunction

    // Results are registered after their word is taken, so a result seen at
    // an edge always belongs to an older word than one taken at the same edge.
    always @(posedge i_clk) begin : watch_channels
        t_filter_result got;
        t_filter_result want;
        if (!i_rst_n) begin
            clear_shadow();
            results_due.delete();
            fails = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_read_data, i_read_valid, i_kept_length, i_current_line_length,
                       i_overwrite_pending, i_escape_phase};
                if (results_due.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected result word: kept %0d line %0d",
                                 i_kept_length, i_current_line_length);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display({"mismatch (expected/actual): data %h/%h valid %0d/%0d",
                                      " kept %0d/%0d line %0d/%0d cr %0d/%0d phase %0d/%0d"},
                                     want.data, got.data, want.valid, got.valid,
                                     want.kept, got.kept, want.line, got.line,
                                     want.cr, got.cr, want.phase, got.phase);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                results_due = {results_due, predict_result(i_req_type, i_data_byte,
                                                           i_chunk_end, i_read_offset)};
            end
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the terminal output escape filter: drives console words and
// read requests, stalls the result side, and reports the verdict.
// Depends on toef_pkg, the design top and toef_scrollback_checker.

module tb;
    import toef_pkg::*;

    localparam int MAX_OFS = (1 << OFS_W) - 1;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_req_type;
    logic [BYTE_W-1:0] i_data_byte;
    logic              i_chunk_end;
    logic [OFS_W-1:0]  i_read_offset;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [BYTE_W-1:0] o_read_data;
    logic              o_read_valid;
    logic [LEN_W-1:0]  o_kept_length;
    logic [LEN_W-1:0]  o_current_line_length;
    logic              o_overwrite_pending;
    logic [1:0]        o_escape_phase;

    int fail_count;
    int pending;

    // Stimulus knobs. The sender asks the receiver for one long hold-off
    // through hold_req; the receiver process counts it out on its own.
    logic hold_req;
    int   calm_words;
    int   chunk_pct;
    int   text_max;
    int   words_sent;

    terminal_output_escape_filter_top dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_req_type            (i_req_type),
        .i_data_byte           (i_data_byte),
        .i_chunk_end           (i_chunk_end),
        .i_read_offset         (i_read_offset),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_read_data           (o_read_data),
        .o_read_valid          (o_read_valid),
        .o_kept_length         (o_kept_length),
        .o_current_line_length (o_current_line_length),
        .o_overwrite_pending   (o_overwrite_pending),
        .o_escape_phase        (o_escape_phase)
    );

    toef_scrollback_checker scrollback_check (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .i_in_stall            (o_in_stall),
        .i_req_type            (i_req_type),
        .i_data_byte           (i_data_byte),
        .i_chunk_end           (i_chunk_end),
        .i_read_offset         (i_read_offset),
        .i_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .i_read_data           (o_read_data),
        .i_read_valid          (o_read_valid),
        .i_kept_length         (o_kept_length),
        .i_current_line_length (o_current_line_length),
        .i_overwrite_pending   (o_overwrite_pending),
        .i_escape_phase        (o_escape_phase),
        .o_fail_count          (fail_count),
        .o_pending             (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Safety net: a hung handshake ends the run here.
    initial begin
        #(64'd200_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // Sender gaps: mostly none or short, now and then a long one, and every so
    // often a calm stretch of back-to-back words.
    function automatic int pick_gap();
        int r;
        if (calm_words > 0) begin
            calm_words--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_words = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 96) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Read offsets mostly land inside the kept bytes, as last reported by the
    // block; the rest probe the boundary and the whole offset range.
    function automatic logic [OFS_W-1:0] pick_offset();
        int kept;
        int r;
        int ofs;
        kept = int'(o_kept_length);
        r    = $urandom_range(0, 99);
        if (kept > 0 && r < 70) begin
            ofs = $urandom_range(0, kept - 1);
        end else if (r < 85) begin
            ofs = kept + $urandom_range(0, 3);
        end else begin
            ofs = $urandom_range(0, MAX_OFS);
        end
        if (ofs > MAX_OFS) ofs = MAX_OFS;
        return OFS_W'(ofs);
    endfunction

    function automatic logic [BYTE_W-1:0] printable_byte();
        return BYTE_W'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic logic [BYTE_W-1:0] text_byte();
        if ($urandom_range(0, 9) == 0) return BYTE_W'($urandom_range(0, 255));
        return printable_byte();
    endfunction

    // Inputs change only at the falling edge. The word is held until the rising
    // edge at which the block does not stall, and valid stays high straight into
    // the next word when there is no gap.
    task automatic send_word(input logic req, input logic [BYTE_W-1:0] b,
                             input logic last, input logic [OFS_W-1:0] ofs);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_data_byte   <= b;
        i_chunk_end   <= last;
        i_read_offset <= ofs;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    // Unused fields of a word carry random values so that every bit moves.
    task automatic append(input logic [BYTE_W-1:0] b);
        send_word(REQ_APPEND, b, $urandom_range(0, 99) < chunk_pct,
                  OFS_W'($urandom_range(0, MAX_OFS)));
    endtask

    task automatic append_last(input logic [BYTE_W-1:0] b);
        send_word(REQ_APPEND, b, 1'b1, OFS_W'($urandom_range(0, MAX_OFS)));
    endtask

    task automatic read_at(input logic [OFS_W-1:0] ofs);
        send_word(REQ_READ, BYTE_W'($urandom_range(0, 255)), 1'(($urandom_range(0, 1))), ofs);
    endtask

    task automatic send_text(input int n);
        for (int i = 0; i < n; i++) begin
            append(text_byte());
        end
    endtask

    // One random piece of console traffic or a read. Most pieces are well-formed:
    // text, line controls and complete CSI or OSC sequences; a few are raw noise
    // that can leave a sequence half open, and the rest are reads.
    task automatic send_random_sequence();
        int kind;
        int n;
        logic [BYTE_W-1:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 28) begin
            send_text($urandom_range(1, text_max));
        end else if (kind < 38) begin
            append(CH_LF);
        end else if (kind < 46) begin
            append(CH_CR);
            if ($urandom_range(0, 3) == 0) begin
                append(CH_LF);
            end else begin
                send_text($urandom_range(1, 6));
            end
        end else if (kind < 52) begin
            repeat ($urandom_range(1, 3)) append(CH_BS);
        end else if (kind < 55) begin
            append(CH_BEL);
        end else if (kind < 67) begin
            append(CH_ESC);
            append(CH_LBRACKET);
            repeat ($urandom_range(0, 4)) append(BYTE_W'($urandom_range(8'h30, 8'h3F)));
            append(BYTE_W'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI)));
        end else if (kind < 75) begin
            append(CH_ESC);
            append(CH_RBRACKET);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                b = printable_byte();
                append((b == CH_BSLASH) ? 8'h41 : b);
            end
            append($urandom_range(0, 1) ? CH_BEL : CH_BSLASH);
        end else if (kind < 79) begin
            append(CH_ESC);
            append(BYTE_W'($urandom_range(0, 255)));
        end else if (kind < 83) begin
            repeat ($urandom_range(1, 6)) append(BYTE_W'($urandom_range(0, 255)));
        end else begin
            read_at(pick_offset());
        end
    endtask

    // The result side: runs of open cycles, most short and some long, broken by
    // stalls of random length. One long hold-off, asked for by the sender, lets
    // the output fill up so that the block stalls its input.
    initial begin : receiver
        int run_len;
        int stall_len;
        int r;
        i_out_stall = 1'b0;
        forever begin
            r       = $urandom_range(0, 99);
            run_len = (r < 10) ? $urandom_range(40, 120) : $urandom_range(1, 6);
            repeat (run_len) @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                stall_len = 400;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 20) begin
                    stall_len = 0;
                end else if (r < 92) begin
                    stall_len = $urandom_range(1, 3);
                end else begin
                    stall_len = $urandom_range(10, 40);
                end
            end
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int target;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_req_type    = REQ_APPEND;
        i_data_byte   = '0;
        i_chunk_end   = 1'b0;
        i_read_offset = '0;
        hold_req      = 1'b0;
        calm_words    = 0;
        chunk_pct     = 0;
        text_max      = 12;
        words_sent    = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: reads of an empty scrollback at both ends of the
        // offset range, extreme byte values, BEL dropped in text and while a
        // carriage return is pending, overwrite of the line, backspace with and
        // without a line to shorten, and each kind of escape sequence.
        read_at('0);
        read_at(OFS_W'(MAX_OFS));
        append(8'h41);
        append(8'hFF);
        append(8'h00);
        append(CH_BEL);
        append(CH_CR);
        append(CH_BEL);
        append(8'h42);
        append(CH_BS);
        append(CH_BS);
        append(CH_CR);
        append(CH_BS);
        append_last(CH_LF);
        append(CH_ESC);
        append(CH_LBRACKET);
        append(8'h31);
        append(CSI_FINAL_HI);
        append(CH_ESC);
        append(CH_RBRACKET);
        append(CH_BEL);
        append(CH_ESC);
        append(CH_RBRACKET);
        append(CH_BSLASH);
        append(CH_ESC);
        append(8'h63);
        read_at('0);

        // Random traffic, opened by the long hold-off on the result side.
        hold_req  = 1'b1;
        chunk_pct = 10;
        target    = words_sent + 500;
        while (words_sent < target) begin
            send_random_sequence();
        end

        // One long line of printable bytes with reads mixed in, so that the
        // line length and the kept length climb together.
        chunk_pct = 0;
        for (int i = 0; i < 200; i++) begin
            if (i % 64 == 63) begin
                read_at(pick_offset());
            end else begin
                append(printable_byte());
            end
        end
        read_at('0);
        read_at(OFS_W'(MAX_OFS));
        read_at(OFS_W'(RING_DEPTH - 2));

        // Chunk end below the cap: the trim leaves the kept bytes in place.
        append_last(printable_byte());
        read_at(OFS_W'(CAP_BYTES * 3 / 4 - 1));
        read_at(OFS_W'(CAP_BYTES * 3 / 4));
        read_at('0);

        // Mixed traffic with longer text and occasional chunk ends.
        chunk_pct = 4;
        text_max  = 40;
        target    = words_sent + 120;
        while (words_sent < target) begin
            send_random_sequence();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain every expected result, then give the output register a margin to
        // show any stray word.
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
